@@ design/uerf_pkg.sv @@
// Shared widths, register indexes, reset values and stage types of the echo range filter.
package uerf_pkg;

    localparam int CH_W       = 2;
    localparam int TS_W       = 16;
    localparam int DIST_W     = 11;
    localparam int TH_W       = 10;
    localparam int FL_W       = 4;
    localparam int TP_W       = 17;
    localparam int MASK_W     = 4;
    localparam int CNT_W      = 4;
    localparam int WIDTH_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_DROP_TH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_TH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_MASK   = 3'd4;

    localparam logic [TH_W-1:0]   RST_DROP_TH      = 10'd15;
    localparam logic [TH_W-1:0]   RST_FRONT_TH     = 10'd40;
    localparam logic [FL_W-1:0]   RST_FILTER_LEN   = 4'd3;
    localparam logic [TP_W-1:0]   RST_TIMER_PERIOD = 17'd60001;
    localparam logic [MASK_W-1:0] RST_FRONT_MASK   = 4'd12;

    localparam logic [DIST_W-1:0] DIST_MAX  = 11'h7FF;
    localparam logic [CNT_W-1:0]  COUNT_MAX = 4'hF;

    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic            measured;
    } t_tag;

endpackage

@@ design/uerf_in_if.sv @@
// Echo edge capture channel: valid, ready and the captured edge.
interface uerf_in_if import uerf_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] channel;
    logic [TS_W-1:0] timestamp_us;

    modport source (output valid, output channel, output timestamp_us, input ready);
    modport sink (input valid, input channel, input timestamp_us, output ready);
endinterface

@@ design/uerf_out_if.sv @@
// Range result channel: valid, ready and one measurement result.
interface uerf_out_if import uerf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   out_channel;
    logic              measured;
    logic [DIST_W-1:0] range_cm;
    logic              alert;

    modport source (output valid, output out_channel, output measured,
                    output range_cm, output alert, input ready);
    modport sink (input valid, input out_channel, input measured,
                  input range_cm, input alert, output ready);
endinterface

@@ design/uerf_div.sv @@
// Registered constant divider: echo width to centimetres by reciprocal multiply, saturated.
module uerf_div import uerf_pkg::*; #(
    parameter int DIVISOR = 58
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [WIDTH_W-1:0]  i_dividend,
    output logic [DIST_W-1:0]   o_quotient
);

    localparam int DIV_L  = $clog2(DIVISOR);
    localparam int DIV_S  = WIDTH_W + DIV_L;
    localparam int M_W    = WIDTH_W + 2;
    localparam int PROD_W = WIDTH_W + M_W;
    localparam logic [M_W-1:0] DIV_M =
        M_W'(((64'd1 << DIV_S) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_quot;
    logic [DIST_W-1:0] n_quotient;
    logic [DIST_W-1:0] r_quotient;

    assign w_prod = PROD_W'(i_dividend) * PROD_W'(DIV_M);
    assign w_quot = w_prod >> DIV_S;

    always_comb begin
        if (w_quot > PROD_W'(DIST_MAX)) begin
            n_quotient = DIST_MAX;
        end else begin
            n_quotient = w_quot[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quotient <= n_quotient;
        end
    end

    assign o_quotient = r_quotient;

endmodule

@@ design/ultrasonic_echo_range_filter.sv @@
// Top level of the ultrasonic echo range filter: edge pairing, distance and hit filtering.
//
// Usage: each transfer on i_echo carries one captured echo edge (channel and
// microsecond timer count). Every transfer yields exactly one result transfer
// on o_range, in order. A channel's edges alternate rising and falling; a
// falling edge reports the echo width divided by US_PER_CM as range_cm,
// with measured set, and alert set while the channel's consecutive hit count
// has reached filter_length. Rising edges and absent channels report zeros.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_wdata while
// no transfer is in flight.
// Pipeline: width and wrap correction, reciprocal multiply, then threshold
// compare and hit count, each registered, the last into o_range.
// Throughput: one item per cycle while o_range.ready is high; the three
// registered stages each advance when the stage ahead is empty or moving.
// Reset: synchronous, active low; all channels expect a rising edge, hit
// counts clear, registers take their reset values, the pipeline empties.
// Stall: when o_range.ready is low the result holds, the stages behind it
// fill, and i_echo.ready drops once all three are occupied.
module ultrasonic_echo_range_filter import uerf_pkg::*; #(
    parameter int CHANNELS  = 4,
    parameter int US_PER_CM = 58
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    uerf_in_if.sink               i_echo,
    uerf_out_if.source            o_range
);

    logic [TH_W-1:0]   r_drop_th;
    logic [TH_W-1:0]   r_front_th;
    logic [FL_W-1:0]   r_filter_len;
    logic [TP_W-1:0]   r_timer_period;
    logic [MASK_W-1:0] r_front_mask;

    logic              r_phase [CHANNELS];
    logic [TS_W-1:0]   r_prev  [CHANNELS];
    logic [CNT_W-1:0]  r_cnt   [CHANNELS];

    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    t_tag              r_tag1;
    t_tag              r_tag2;
    logic [WIDTH_W-1:0] r_width1;

    logic [CH_W-1:0]   r_out_channel;
    logic              r_out_measured;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_alert;

    logic              w_en1;
    logic              w_en2;
    logic              w_en3;
    logic              w_xfer;

    logic              w_present;
    logic              w_phase;
    logic [TS_W-1:0]   w_prev;
    logic              w_measured;
    logic [TS_W:0]     w_diff;
    logic [TS_W+1:0]   w_wrap_sum;
    logic [WIDTH_W-1:0] n_width1;

    logic [DIST_W-1:0] w_dist;
    logic [CNT_W-1:0]  w_cnt;
    logic              w_front;
    logic              w_hit;
    logic [CNT_W-1:0]  n_cnt;
    logic              n_alert;

    assign w_en3  = !r_v3 || o_range.ready;
    assign w_en2  = !r_v2 || w_en3;
    assign w_en1  = !r_v1 || w_en2;
    assign w_xfer = i_echo.valid && w_en1;

    assign i_echo.ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_th      <= RST_DROP_TH;
            r_front_th     <= RST_FRONT_TH;
            r_filter_len   <= RST_FILTER_LEN;
            r_timer_period <= RST_TIMER_PERIOD;
            r_front_mask   <= RST_FRONT_MASK;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DROP_TH:      r_drop_th      <= i_cfg_wdata[TH_W-1:0];
                REG_FRONT_TH:     r_front_th     <= i_cfg_wdata[TH_W-1:0];
                REG_FILTER_LEN:   r_filter_len   <= i_cfg_wdata[FL_W-1:0];
                REG_TIMER_PERIOD: r_timer_period <= i_cfg_wdata[TP_W-1:0];
                REG_FRONT_MASK:   r_front_mask   <= i_cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_present = 1'b0;
        w_phase   = 1'b0;
        w_prev    = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (int'(i_echo.channel) == c) begin
                w_present = 1'b1;
                w_phase   = r_phase[c];
                w_prev    = r_prev[c];
            end
        end
    end

    assign w_measured = w_present && w_phase;
    assign w_diff     = {1'b0, i_echo.timestamp_us} - {1'b0, w_prev};
    assign w_wrap_sum = {2'b00, i_echo.timestamp_us} + {1'b0, r_timer_period};

    always_comb begin
        if (!w_measured) begin
            n_width1 = '0;
        end else if (i_echo.timestamp_us >= w_prev) begin
            n_width1 = WIDTH_W'(w_diff);
        end else if (w_wrap_sum >= {2'b00, w_prev}) begin
            n_width1 = WIDTH_W'(w_wrap_sum - {2'b00, w_prev});
        end else begin
            n_width1 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_phase[c] <= 1'b0;
                r_prev[c]  <= '0;
            end
        end else if (w_xfer) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (int'(i_echo.channel) == c) begin
                    r_phase[c] <= !r_phase[c];
                    r_prev[c]  <= i_echo.timestamp_us;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_echo.valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_tag1.channel  <= i_echo.channel;
            r_tag1.measured <= w_measured;
            r_width1        <= n_width1;
        end
        if (w_en2) begin
            r_tag2 <= r_tag1;
        end
    end

    uerf_div #(
        .DIVISOR (US_PER_CM)
    ) u_div (
        .i_clk      (i_clk),
        .i_en       (w_en2),
        .i_dividend (r_width1),
        .o_quotient (w_dist)
    );

    always_comb begin
        w_cnt = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (int'(r_tag2.channel) == c) begin
                w_cnt = r_cnt[c];
            end
        end
    end

    assign w_front = r_front_mask[r_tag2.channel];
    assign w_hit   = w_front ? (w_dist < {1'b0, r_front_th}) : (w_dist > {1'b0, r_drop_th});

    always_comb begin
        if (!w_hit) begin
            n_cnt = '0;
        end else if (w_cnt < COUNT_MAX) begin
            n_cnt = w_cnt + CNT_W'(1);
        end else begin
            n_cnt = w_cnt;
        end
    end

    assign n_alert = r_tag2.measured && w_hit && (n_cnt >= r_filter_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_cnt[c] <= '0;
            end
        end else if (w_en3 && r_v2 && r_tag2.measured) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (int'(r_tag2.channel) == c) begin
                    r_cnt[c] <= n_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_out_channel  <= r_tag2.channel;
            r_out_measured <= r_tag2.measured;
            r_out_dist     <= w_dist;
            r_out_alert    <= n_alert;
        end
    end

    assign o_range.valid       = r_v3;
    assign o_range.out_channel = r_out_channel;
    assign o_range.measured    = r_out_measured;
    assign o_range.range_cm    = r_out_dist;
    assign o_range.alert       = r_out_alert;

    a_xfer_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer |=> r_v1)
        else $error("accepted edge did not enter the first stage");

    a_alert_needs_measure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_range.valid && o_range.alert |-> o_range.measured)
        else $error("alert raised on a result without a measurement");

    a_idle_edge_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_range.valid && !o_range.measured |-> o_range.range_cm == '0)
        else $error("nonzero distance on an unmeasured result");

    a_stage2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !w_en3 |=> r_v2 && $stable(r_tag2))
        else $error("second stage lost its item under stall");

endmodule
